FILE: sv/iee_pkg.sv
`default_nettype none
package iee_pkg;

  // Default stack depths
  localparam int OPERAND_DEPTH_DEF  = 16;
  localparam int OPERATOR_DEPTH_DEF = 16;

  // Token queue between front and back
  localparam int TOKQ_DEPTH = 4;

  // Operator codes as held on the operator stack
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_LPAR = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIVZERO   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  // Token kinds
  localparam logic [2:0] TK_NONE  = 3'd0;
  localparam logic [2:0] TK_DIGIT = 3'd1;
  localparam logic [2:0] TK_OP    = 3'd2;
  localparam logic [2:0] TK_LPAR  = 3'd3;
  localparam logic [2:0] TK_RPAR  = 3'd4;

  // ASCII codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] CH_LPAR  = 7'h28;
  localparam logic [6:0] CH_RPAR  = 7'h29;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] val;   // digit value or operator code
    logic       last;
  } tok_t;

  // High precedence: * and /
  function automatic logic prec_hi(input logic [2:0] op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage
`default_nettype wire

FILE: sv/iee_ram.sv
`default_nettype none
module iee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/iee_front.sv
`default_nettype none
module iee_front
  import iee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  output logic          tok_valid,
  output tok_t          tok,
  input  wire logic     tok_deq
);

  localparam int PW = $clog2(TOKQ_DEPTH);
  localparam int CW = $clog2(TOKQ_DEPTH + 1);

  tok_t           q_r [TOKQ_DEPTH];
  logic [PW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  tok_t           cls;
  logic [6:0]     ch;
  logic           enq, deq;

  // Classify the incoming character
  always_comb begin
    ch       = in_data.character;
    cls.last = in_data.last;
    cls.kind = TK_NONE;
    cls.val  = 4'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cls.kind = TK_DIGIT;
      cls.val  = 4'(ch - CH_ZERO);
    end else if (ch == CH_PLUS) begin
      cls.kind = TK_OP;
      cls.val  = {1'b0, OP_ADD};
    end else if (ch == CH_MINUS) begin
      cls.kind = TK_OP;
      cls.val  = {1'b0, OP_SUB};
    end else if (ch == CH_STAR) begin
      cls.kind = TK_OP;
      cls.val  = {1'b0, OP_MUL};
    end else if (ch == CH_SLASH) begin
      cls.kind = TK_OP;
      cls.val  = {1'b0, OP_DIV};
    end else if (ch == CH_LPAR) begin
      cls.kind = TK_LPAR;
    end else if (ch == CH_RPAR) begin
      cls.kind = TK_RPAR;
    end
  end

  assign in_full   = (cnt_r == CW'(TOKQ_DEPTH));
  assign tok_valid = (cnt_r != '0);
  assign tok       = q_r[head_r];
  assign enq       = in_push && !in_full;
  assign deq       = tok_deq && tok_valid;

  // Queue pointers
  always_comb begin
    head_nxt = deq ? head_r + PW'(1) : head_r;
    tail_nxt = enq ? tail_r + PW'(1) : tail_r;
    cnt_nxt  = cnt_r + CW'(enq) - CW'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[tail_r] <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: sv/iee_div.sv
`default_nettype none
module iee_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      q
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, mb_r, mb_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] shifted, diff;

  // One quotient bit per cycle, restoring, on magnitudes
  always_comb begin
    shifted  = {rem_r, quo_r[31]};
    diff     = shifted - {1'b0, mb_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    mb_nxt   = mb_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      rem_nxt  = '0;
      quo_nxt  = a[31] ? (32'd0 - a) : a;
      mb_nxt   = b[31] ? (32'd0 - b) : b;
      neg_nxt  = a[31] ^ b[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign q    = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule
`default_nettype wire

FILE: sv/iee_back.sv
`default_nettype none
module iee_back
  import iee_pkg::*;
#(
  parameter int OPERAND_DEPTH  = OPERAND_DEPTH_DEF,
  parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  tok_valid,
  input  wire tok_t  tok,
  output logic       tok_deq,
  output logic       out_empty,
  input  wire logic  out_pop,
  output out_item_t  out_data
);

  localparam int OAW = $clog2(OPERAND_DEPTH);
  localparam int OCW = $clog2(OPERAND_DEPTH + 1);
  localparam int PAW = $clog2(OPERATOR_DEPTH);
  localparam int PCW = $clog2(OPERATOR_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOP = 4'd1;
  localparam logic [3:0] S_TOP  = 4'd2;
  localparam logic [3:0] S_RPOP = 4'd3;
  localparam logic [3:0] S_RB   = 4'd4;
  localparam logic [3:0] S_RA   = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_EXIT = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  localparam logic [1:0] M_OP   = 2'd0;
  localparam logic [1:0] M_RPAR = 2'd1;
  localparam logic [1:0] M_END  = 2'd2;

  logic [3:0]     state_r, state_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [2:0]     op_r, op_nxt, top_r, top_nxt;
  logic           last_r, last_nxt;
  logic [OCW-1:0] ocnt_r, ocnt_nxt, ocnt_m1, ocnt_m2;
  logic [PCW-1:0] pcnt_r, pcnt_nxt, pcnt_m1;
  logic [1:0]     err_r, err_nxt;
  logic [31:0]    cur_r, cur_nxt, b_r, b_nxt, res_r, res_nxt;
  logic           ov_r, ov_nxt;
  out_item_t      od_r, od_nxt;

  logic           o_we, p_we;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [31:0]    o_wdata, o_rdata;
  logic [2:0]     p_wdata, p_rdata;
  logic           div_start, div_done;
  logic [31:0]    div_q, cur_x10;
  logic           o_full, p_full;

  assign ocnt_m1 = ocnt_r - OCW'(1);
  assign ocnt_m2 = ocnt_r - OCW'(2);
  assign pcnt_m1 = pcnt_r - PCW'(1);
  assign o_full  = (ocnt_r == OCW'(OPERAND_DEPTH));
  assign p_full  = (pcnt_r == PCW'(OPERATOR_DEPTH));
  assign cur_x10 = {cur_r[28:0], 3'b000} + {cur_r[30:0], 1'b0};

  iee_ram #(.WIDTH(32), .DEPTH(OPERAND_DEPTH)) u_opnd (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_oper (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  iee_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(o_rdata), .b(b_r),
    .done(div_done), .q(div_q)
  );

  // Evaluation sequencer
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    op_nxt    = op_r;
    top_nxt   = top_r;
    last_nxt  = last_r;
    ocnt_nxt  = ocnt_r;
    pcnt_nxt  = pcnt_r;
    err_nxt   = err_r;
    cur_nxt   = cur_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    tok_deq   = 1'b0;
    o_we      = 1'b0;
    o_waddr   = ocnt_r[OAW-1:0];
    o_wdata   = cur_r;
    o_raddr   = ocnt_m1[OAW-1:0];
    p_we      = 1'b0;
    p_waddr   = pcnt_r[PAW-1:0];
    p_wdata   = op_r;
    p_raddr   = pcnt_m1[PAW-1:0];
    div_start = 1'b0;

    if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (tok_valid) begin
          tok_deq  = 1'b1;
          last_nxt = tok.last;
          state_nxt = S_EXIT;
          if (err_r == ST_OK) begin
            unique case (tok.kind)
              TK_DIGIT: cur_nxt = cur_x10 + {28'd0, tok.val};
              TK_LPAR: begin
                cur_nxt = '0;
                p_wdata = OP_LPAR;
                if (p_full) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  p_we     = 1'b1;
                  pcnt_nxt = pcnt_r + PCW'(1);
                end
              end
              TK_RPAR, TK_OP: begin
                mode_nxt  = (tok.kind == TK_OP) ? M_OP : M_RPAR;
                op_nxt    = tok.val[2:0];
                state_nxt = S_LOOP;
                if (o_full) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  o_we     = 1'b1;
                  ocnt_nxt = ocnt_r + OCW'(1);
                end
              end
              default: ;
            endcase
          end
        end
      end

      S_LOOP: begin
        if (err_r != ST_OK) begin
          state_nxt = (mode_r == M_END) ? S_EMIT : S_EXIT;
        end else if (pcnt_r == '0) begin
          unique case (mode_r)
            M_OP: begin
              if (p_full) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                p_we     = 1'b1;
                pcnt_nxt = pcnt_r + PCW'(1);
              end
              cur_nxt   = '0;
              state_nxt = S_EXIT;
            end
            M_RPAR: begin
              err_nxt   = ST_MALFORMED;
              state_nxt = S_EXIT;
            end
            default: begin
              // End of expression: exactly one operand must remain
              o_raddr = '0;
              if (ocnt_r != OCW'(1)) begin
                err_nxt   = ST_MALFORMED;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_FIN;
              end
            end
          endcase
        end else begin
          state_nxt = S_TOP;
        end
      end

      S_TOP: begin
        top_nxt = p_rdata;
        if (mode_r == M_OP &&
            (p_rdata == OP_LPAR || (!prec_hi(p_rdata) && prec_hi(op_r)))) begin
          if (p_full) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            p_we     = 1'b1;
            pcnt_nxt = pcnt_r + PCW'(1);
          end
          cur_nxt   = '0;
          state_nxt = S_EXIT;
        end else if (mode_r == M_RPAR && p_rdata == OP_LPAR) begin
          pcnt_nxt  = pcnt_m1;
          state_nxt = S_RPOP;
        end else if (ocnt_r < OCW'(2) || p_rdata == OP_LPAR) begin
          err_nxt   = ST_MALFORMED;
          state_nxt = S_LOOP;
        end else begin
          // Reduce: pop operator, fetch right operand
          pcnt_nxt  = pcnt_m1;
          state_nxt = S_RB;
        end
      end

      S_RPOP: begin
        cur_nxt   = o_rdata;
        ocnt_nxt  = ocnt_m1;
        state_nxt = S_EXIT;
      end

      S_RB: begin
        b_nxt     = o_rdata;
        o_raddr   = ocnt_m2[OAW-1:0];
        state_nxt = S_RA;
      end

      S_RA: begin
        unique case (top_r)
          OP_ADD: begin
            res_nxt   = o_rdata + b_r;
            state_nxt = S_WR;
          end
          OP_SUB: begin
            res_nxt   = o_rdata - b_r;
            state_nxt = S_WR;
          end
          OP_MUL: begin
            res_nxt   = o_rdata * b_r;
            state_nxt = S_WR;
          end
          default: begin
            if (b_r == '0) begin
              err_nxt   = ST_DIVZERO;
              state_nxt = S_LOOP;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = S_WR;
        end
      end

      S_WR: begin
        o_we      = 1'b1;
        o_waddr   = ocnt_m2[OAW-1:0];
        o_wdata   = res_r;
        ocnt_nxt  = ocnt_m1;
        state_nxt = S_LOOP;
      end

      S_EXIT: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (err_r != ST_OK) begin
          state_nxt = S_EMIT;
        end else begin
          // Final operand, then reduce everything left
          mode_nxt  = M_END;
          state_nxt = S_LOOP;
          if (o_full) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            o_we     = 1'b1;
            ocnt_nxt = ocnt_r + OCW'(1);
          end
        end
      end

      S_FIN: begin
        res_nxt   = o_rdata;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!ov_r || out_pop) begin
          ov_nxt          = 1'b1;
          od_nxt.value    = (err_r == ST_OK) ? res_r : '0;
          od_nxt.status   = err_r;
          ocnt_nxt        = '0;
          pcnt_nxt        = '0;
          cur_nxt         = '0;
          err_nxt         = ST_OK;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ocnt_r  <= '0;
      pcnt_r  <= '0;
      err_r   <= ST_OK;
      cur_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ocnt_r  <= ocnt_nxt;
      pcnt_r  <= pcnt_nxt;
      err_r   <= err_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    op_r   <= op_nxt;
    top_r  <= top_nxt;
    last_r <= last_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    od_r   <= od_nxt;
  end

  assign out_empty = !ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

FILE: sv/infix_expression_evaluator_top.sv
`default_nettype none
// Channel   Ports                          Beat
// input     in_push, in_full, in_data      one character (+ last flag)
// result    out_empty, out_pop, out_data   value and status, once per expression
//
// In the back end an operator or ')' may set off reductions, and a division
// runs on the bit-serial divider. The last character adds its final reductions
// and then loads the result register, which waits while a beat is held there.
// The front queue holds 4 characters, so input is taken while the back works.
// Reset (rst_n low, synchronous) empties both queues and the stacks.
module infix_expression_evaluator_top
  import iee_pkg::*;
#(
  parameter int OPERAND_DEPTH  = OPERAND_DEPTH_DEF,
  parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_data
);

  logic tok_valid, tok_deq;
  tok_t tok;

  iee_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .tok_valid(tok_valid), .tok(tok), .tok_deq(tok_deq)
  );

  iee_back #(
    .OPERAND_DEPTH(OPERAND_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .tok_valid(tok_valid), .tok(tok),
    .tok_deq(tok_deq), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data)
  );

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != ST_OK) |-> (out_data.value == 0))
    else $error("error result with non-zero value");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

endmodule
`default_nettype wire
